>>> hw/rtl/mpwm_pkg.sv
package mpwm_pkg;

  // Widths fixed by the item format.
  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int STEP_W  = 7;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] PHASE_STEP_RST = 8'd7;
  localparam logic [BYTE_W-1:0] RAMP_STEP_RST  = 8'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_LEVEL = 2'd1,
    CMD_SET_PULSE = 2'd2,
    CMD_RSVD      = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0,
    REG_RAMP_STEP  = 1'b1
  } cfg_reg_t;

  // Per-channel control for one processed item.
  typedef struct packed {
    logic              wr_level;
    logic              wr_mode;
    logic              ramp;
    logic [BYTE_W-1:0] data;
  } chan_ctl_t;

endpackage

>>> hw/rtl/mpwm_chan.sv
module mpwm_chan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpwm_pkg::chan_ctl_t           ctl,
  input  logic [mpwm_pkg::BYTE_W-1:0]   phase,
  output logic                          pwm_bit
);

  logic [mpwm_pkg::BYTE_W-1:0] level_r, level_nxt;
  logic [mpwm_pkg::BYTE_W-1:0] target_r, target_nxt;
  logic [mpwm_pkg::BYTE_W-1:0] mode_r, mode_nxt;
  logic [mpwm_pkg::STEP_W-1:0] step;
  logic                        step_nz;
  logic [mpwm_pkg::BYTE_W:0]   rise_sum;

  assign pwm_bit  = (level_r > phase);
  assign step     = mode_r[mpwm_pkg::BYTE_W-1:1];
  assign step_nz  = (step != '0);
  assign rise_sum = {1'b0, level_r} + {2'b00, step};

  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    mode_nxt   = mode_r;
    if (ctl.wr_level) begin
      level_nxt  = ctl.data;
      target_nxt = ctl.data;
      mode_nxt   = '0;
    end else if (ctl.wr_mode) begin
      mode_nxt = ctl.data;
    end else if (ctl.ramp) begin
      if (mode_r[0]) begin
        // Falling: clamp at zero and turn around.
        if (step_nz && (level_r <= {1'b0, step})) begin
          level_nxt   = '0;
          mode_nxt[0] = 1'b0;
        end else begin
          level_nxt = level_r - {1'b0, step};
        end
      end else begin
        // Rising: clamp at the target and turn around.
        if (step_nz && (rise_sum >= {1'b0, target_r})) begin
          level_nxt   = target_r;
          mode_nxt[0] = 1'b1;
        end else begin
          level_nxt = rise_sum[mpwm_pkg::BYTE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      target_r <= '0;
      mode_r   <= '0;
    end else begin
      level_r  <= level_nxt;
      target_r <= target_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

>>> hw/rtl/multichannel_pwm_with_breathing_ramp.sv
// Multichannel PWM with a per-channel breathing ramp. Each input transfer
// carries a command: a tick compares every channel level with an 8-bit phase
// counter and reports one PWM bit per channel, set-level loads a channel's
// level and target and stops its ramp, and set-pulse loads the channel's
// mode byte (bit 0 falling, bits 7..1 ramp step). Every command yields exactly
// one result transfer with the current PWM bits and a changed flag that is
// set only when a tick altered the bits. Set commands for a channel number
// at or above CHANNELS, and the reserved command code, change nothing. The
// block takes one item per clock cycle when the output is not stalled; a
// result is offered on the output once its input transfer has loaded the
// input register and the result register has taken its result, and the rate
// is set by the single pass of compare and ramp logic between those two
// registers. The user must write phase_step and ramp_step through the cfg
// port only while the block is idle; the block does not enforce this.
module multichannel_pwm_with_breathing_ramp #(
  parameter int CHANNELS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write port.
  input  logic                         cfg_wr_en,
  input  logic [0:0]                   cfg_index,
  input  logic [mpwm_pkg::BYTE_W-1:0]  cfg_wdata,
  // Command channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mpwm_pkg::CMD_W-1:0]   in_cmd,
  input  logic [mpwm_pkg::CHAN_W-1:0]  in_channel,
  input  logic [mpwm_pkg::BYTE_W-1:0]  in_value,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CHANNELS-1:0]          out_pwm_bits,
  output logic                         out_changed
);

  localparam int CW = mpwm_pkg::CHAN_W;

  // Configuration registers.
  logic [mpwm_pkg::BYTE_W-1:0] phase_step_r;
  logic [mpwm_pkg::BYTE_W-1:0] ramp_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= mpwm_pkg::PHASE_STEP_RST;
      ramp_step_r  <= mpwm_pkg::RAMP_STEP_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == mpwm_pkg::REG_PHASE_STEP) begin
        phase_step_r <= cfg_wdata;
      end else begin
        ramp_step_r <= cfg_wdata;
      end
    end
  end

  // Input register. It holds one command until the result register can take
  // its result; the input side stalls only while a held command cannot move.
  logic                        s1_valid_r;
  logic [mpwm_pkg::CMD_W-1:0]  s1_cmd_r;
  logic [CW-1:0]               s1_channel_r;
  logic [mpwm_pkg::BYTE_W-1:0] s1_value_r;
  logic                        out_free;
  logic                        fire;
  logic                        in_xfer;

  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r     <= in_cmd;
      s1_channel_r <= in_channel;
      s1_value_r   <= in_value;
    end
  end

  // Global tick state: phase counter, ramp divider and the last PWM bits.
  logic [mpwm_pkg::BYTE_W-1:0] phase_r, phase_nxt;
  logic [mpwm_pkg::BYTE_W-1:0] div_r, div_nxt;
  logic [CHANNELS-1:0]         last_bits_r;
  logic [CHANNELS-1:0]         bits;
  logic                        is_tick;
  logic                        is_set_level;
  logic                        is_set_pulse;
  logic                        ramp_en;
  logic                        tick_fire;

  assign is_tick      = (s1_cmd_r == mpwm_pkg::CMD_TICK);
  assign is_set_level = (s1_cmd_r == mpwm_pkg::CMD_SET_LEVEL);
  assign is_set_pulse = (s1_cmd_r == mpwm_pkg::CMD_SET_PULSE);
  assign tick_fire    = fire && is_tick;

  // The divider steps once per PWM period, on the tick that sees phase zero;
  // the ramp moves every level when the divider wraps to zero.
  always_comb begin
    phase_nxt = phase_r;
    div_nxt   = div_r;
    if (tick_fire) begin
      phase_nxt = phase_r + phase_step_r;
      if (phase_r == '0) begin
        div_nxt = div_r + ramp_step_r;
      end
    end
  end

  assign ramp_en = tick_fire && (phase_r == '0) && (div_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      div_r       <= '0;
      last_bits_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      div_r   <= div_nxt;
      if (tick_fire) begin
        last_bits_r <= bits;
      end
    end
  end

  // One slice per channel. The PWM bit uses the level before any ramp move
  // of the same tick.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    mpwm_pkg::chan_ctl_t ctl;
    logic                sel;

    assign sel          = (s1_channel_r == CW'(i));
    assign ctl.wr_level = fire && is_set_level && sel;
    assign ctl.wr_mode  = fire && is_set_pulse && sel;
    assign ctl.ramp     = ramp_en;
    assign ctl.data     = s1_value_r;

    mpwm_chan u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .phase   (phase_r),
      .pwm_bit (bits[i])
    );
  end

  // Result register. Non-tick commands report the held bits unchanged.
  logic                out_valid_r;
  logic [CHANNELS-1:0] out_pwm_bits_r;
  logic                out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pwm_bits_r <= '0;
      out_changed_r  <= 1'b0;
    end else if (fire) begin
      out_pwm_bits_r <= is_tick ? bits : last_bits_r;
      out_changed_r  <= is_tick && (bits != last_bits_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pwm_bits = out_pwm_bits_r;
  assign out_changed  = out_changed_r;

  // While a result is valid, the result register mirrors the bits held for the next result.
  a_out_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pwm_bits_r == last_bits_r))
    else $error("result bits differ from held PWM bits");

  // Only ticks may report a change.
  a_changed_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_tick) |=> !out_changed_r)
    else $error("changed flag set by a set command");

  // Set commands and idle cycles leave the phase counter alone.
  a_phase_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_fire |=> $stable(phase_r))
    else $error("phase moved without a tick");

  // A held command is not dropped while the result side is blocked.
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !fire) |=> s1_valid_r)
    else $error("held command lost");

endmodule
